FILE: rtl/q8dp_pkg.sv
// ----------------------------------------------------------------------------
// q8dp_pkg: shared types and a function for the Q8_0 block dot product
// Holds the controller state type, the controller-datapath command and
// status structs, and the half-precision widening function.
// ----------------------------------------------------------------------------
package q8dp_pkg;

    localparam int BYTES_PER_BLOCK = 32;
    localparam int LANES           = 8;
    localparam int LANE_STEPS      = BYTES_PER_BLOCK / LANES;
    localparam int STEP_W          = $clog2(LANE_STEPS);
    localparam int DOT_W           = 21;
    localparam logic [31:0] QNAN   = 32'h7FC0_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DOT,
        ST_SCALE,
        ST_MUL,
        ST_ADD
    } t_state;

    typedef struct packed {
        logic load;
        logic dot_step;
        logic scale_mul;
        logic term_mul;
        logic acc_add;
        logic acc_clear;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic dot_done;
    } t_status;

    // Widen IEEE half bits to single bits (exact).
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic        s;
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [7:0]  e32;
        logic [9:0]  m;
        int          lz;
        begin
            s   = h[15];
            ex  = h[14:10];
            man = h[9:0];
            lz  = 0;
            for (int i = 9; i >= 0; i--) begin
                if (man[i] && lz == 0) begin
                    lz = 10 - i;
                end
            end
            if (ex == 5'd0) begin
                if (man == 10'd0) begin
                    half_to_single = {s, 31'd0};
                end else begin
                    e32 = 8'(113 - lz);
                    m   = 10'(man << lz);
                    half_to_single = {s, e32, m, 13'd0};
                end
            end else if (ex == 5'd31) begin
                half_to_single = {s, 8'hFF, man, 13'd0};
            end else begin
                half_to_single = {s, 8'(ex + 8'd112), man, 13'd0};
            end
        end
    endfunction

endpackage

FILE: rtl/q8_block_dot_product_core.sv
// ----------------------------------------------------------------------------
// q8_block_dot_product_core: Q8_0 block dot product with float running sum
// Top level joining the sequencer and the arithmetic datapath.
// ----------------------------------------------------------------------------
// Each request carries one pair of 32-byte signed blocks with half-precision
// scales. The core forms the exact integer dot product in four lane steps
// (eight byte lanes per cycle), multiplies the two widened scales, scales the
// dot product and adds it into a single-precision running sum, rounding to
// nearest-even at each step. A request passes through a load, four lane
// steps, the scale multiply, the term multiply and the add before the next one
// is taken; the lane loop and the serial multiply chain set this. tlast on
// input marks the final pair: the sum is then captured in an output register
// and held until taken, while further requests proceed. Only the add of a
// later final pair waits while an earlier sum is still untaken, stretching
// that request by the stall. tuser bit 0 clears the sum before the pair is
// added. NaN sums appear as 0x7FC00000.
module q8_block_dot_product_core import q8dp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: x_scale[15:0], y_scale[31:16], x_word0..3[287:32], y_word0..3[543:288]
    input  logic [543:0] s_axis_tdata,
    // tuser: first_block
    input  logic         s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: dot_sum[31:0]
    output logic [31:0]  m_axis_tdata
);
    t_cmd    cmd;
    t_status status;

    q8dp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (s_axis_tvalid),
        .i_first     (s_axis_tuser),
        .i_last      (s_axis_tlast),
        .i_out_taken (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_ready     (s_axis_tready),
        .o_out_valid (m_axis_tvalid)
    );

    q8dp_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_status  (status),
        .i_x_scale (s_axis_tdata[15:0]),
        .i_y_scale (s_axis_tdata[31:16]),
        .i_x_bytes (s_axis_tdata[287:32]),
        .i_y_bytes (s_axis_tdata[543:288]),
        .o_sum     (m_axis_tdata)
    );
endmodule

FILE: rtl/q8dp_fmul.sv
// ----------------------------------------------------------------------------
// q8dp_fmul: single-precision multiply, round to nearest-even
// Combinational; full subnormal, infinity and NaN handling.
// ----------------------------------------------------------------------------
module q8dp_fmul import q8dp_pkg::*; (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_p
);
    logic        sa, sb, sp;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [47:0] prod;
    logic [47:0] nprod;
    int          lz;
    int          e;
    int          sh;
    logic [49:0] wide;
    logic [23:0] mant;
    logic        g, st;
    logic [24:0] rnd;

    always_comb begin
        sa = i_a[31];
        sb = i_b[31];
        sp = sa ^ sb;
        ea = i_a[30:23];
        eb = i_b[30:23];
        ma = {(ea != 8'd0), i_a[22:0]};
        mb = {(eb != 8'd0), i_b[22:0]};
        a_nan  = (ea == 8'hFF) && (i_a[22:0] != 23'd0);
        b_nan  = (eb == 8'hFF) && (i_b[22:0] != 23'd0);
        a_inf  = (ea == 8'hFF) && (i_a[22:0] == 23'd0);
        b_inf  = (eb == 8'hFF) && (i_b[22:0] == 23'd0);
        a_zero = (ea == 8'd0) && (i_a[22:0] == 23'd0);
        b_zero = (eb == 8'd0) && (i_b[22:0] == 23'd0);
        prod   = ma * mb;
        lz = 47;
        for (int i = 0; i < 48; i++) begin
            if (prod[i]) begin
                lz = 47 - i;
            end
        end
        nprod = prod << lz;
        // value = nprod[47].nprod[46:0] * 2^(e-127)
        e = int'((ea == 8'd0) ? 8'd1 : ea) + int'((eb == 8'd0) ? 8'd1 : eb)
            - 127 + 1 - lz;
        sh   = 0;
        if (e < 1) begin
            sh = 1 - e;
            e  = 0;
        end
        if (sh > 49) begin
            sh = 49;
        end
        wide = {nprod, 2'b00} >> sh;
        mant = wide[49:26];
        g    = wide[25];
        st   = (wide[24:0] != 25'd0) || ((({nprod, 2'b00} << (50 - sh)) != 50'd0)
               && sh != 0);
        rnd  = {1'b0, mant} + 25'(g && (st || mant[0]));
        if (rnd[24]) begin
            rnd = rnd >> 1;
            e   = e + 1;
        end else if (e == 0 && rnd[23]) begin
            e = 1;
        end
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
            o_p = QNAN;
        end else if (a_inf || b_inf) begin
            o_p = {sp, 8'hFF, 23'd0};
        end else if (a_zero || b_zero) begin
            o_p = {sp, 31'd0};
        end else if (e >= 255) begin
            o_p = {sp, 8'hFF, 23'd0};
        end else begin
            o_p = {sp, 8'(e), rnd[22:0]};
        end
    end
endmodule

FILE: rtl/q8dp_fadd.sv
// ----------------------------------------------------------------------------
// q8dp_fadd: single-precision add, round to nearest-even
// Combinational; exact sum of zeros follows IEEE sign rules.
// ----------------------------------------------------------------------------
module q8dp_fadd import q8dp_pkg::*; (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_s
);
    logic        sa, sb, sbig, ssml, sr;
    logic [7:0]  ea, eb, eb_big, es_sml;
    logic [26:0] mbig, msml, mal;
    logic [27:0] sum;
    logic        a_nan, b_nan, a_inf, b_inf;
    logic [7:0]  d;
    int          lz;
    int          e;
    logic [27:0] nsum;
    logic [24:0] rnd;
    logic        g, st;

    always_comb begin
        sa = i_a[31];
        sb = i_b[31];
        ea = i_a[30:23];
        eb = i_b[30:23];
        a_nan = (ea == 8'hFF) && (i_a[22:0] != 23'd0);
        b_nan = (eb == 8'hFF) && (i_b[22:0] != 23'd0);
        a_inf = (ea == 8'hFF) && (i_a[22:0] == 23'd0);
        b_inf = (eb == 8'hFF) && (i_b[22:0] == 23'd0);
        if (i_a[30:0] >= i_b[30:0]) begin
            sbig = sa; ssml = sb;
            eb_big = (ea == 8'd0) ? 8'd1 : ea;
            es_sml = (eb == 8'd0) ? 8'd1 : eb;
            mbig = {(ea != 8'd0), i_a[22:0], 3'b000};
            msml = {(eb != 8'd0), i_b[22:0], 3'b000};
        end else begin
            sbig = sb; ssml = sa;
            eb_big = (eb == 8'd0) ? 8'd1 : eb;
            es_sml = (ea == 8'd0) ? 8'd1 : ea;
            mbig = {(eb != 8'd0), i_b[22:0], 3'b000};
            msml = {(ea != 8'd0), i_a[22:0], 3'b000};
        end
        d   = eb_big - es_sml;
        mal = (d > 8'd26) ? 27'd0 : (msml >> d);
        mal[0] = mal[0] | ((d > 8'd26) ? (msml != 27'd0)
                 : ((msml & ~({27{1'b1}} << d)) != 27'd0));
        sum = (sbig == ssml) ? ({1'b0, mbig} + {1'b0, mal})
                             : ({1'b0, mbig} - {1'b0, mal});
        lz = 27;
        for (int i = 0; i < 28; i++) begin
            if (sum[i]) begin
                lz = 27 - i;
            end
        end
        // sum bit 26 is the hidden-bit position at exponent eb_big
        e = int'(eb_big) + 1 - lz;
        if (e < 1) begin
            lz = lz - (1 - e);
            e  = 0;
        end
        nsum = sum << lz;
        st   = 1'b0;
        if (lz < 0) begin
            nsum = sum >> (-lz);
            st   = (sum & ~({28{1'b1}} << (-lz))) != 28'd0;
        end
        g   = nsum[3];
        st  = st | (nsum[2:0] != 3'd0);
        rnd = {1'b0, nsum[27:4]} + 25'(g && (st || nsum[4]));
        if (rnd[24]) begin
            rnd = rnd >> 1;
            e   = e + 1;
        end else if (e == 0 && rnd[23]) begin
            e = 1;
        end
        sr = sbig;
        if (a_nan || b_nan || (a_inf && b_inf && sa != sb)) begin
            o_s = QNAN;
        end else if (a_inf) begin
            o_s = i_a;
        end else if (b_inf) begin
            o_s = i_b;
        end else if (sum == 28'd0) begin
            o_s = {sa & sb, 31'd0};
        end else if (e >= 255) begin
            o_s = {sr, 8'hFF, 23'd0};
        end else begin
            o_s = {sr, 8'(e), rnd[22:0]};
        end
    end
endmodule

FILE: rtl/q8dp_datapath.sv
// ----------------------------------------------------------------------------
// q8dp_datapath: operand registers, dot lanes, scale and accumulate
// Eight byte lanes per step over four steps, then two multiplies and an add.
// ----------------------------------------------------------------------------
module q8dp_datapath import q8dp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    output t_status      o_status,
    input  logic [15:0]  i_x_scale,
    input  logic [15:0]  i_y_scale,
    input  logic [255:0] i_x_bytes,
    input  logic [255:0] i_y_bytes,
    output logic [31:0]  o_sum
);
    logic [255:0]      r_x, r_y;
    logic [15:0]       r_xs, r_ys;
    logic [STEP_W-1:0] r_step;
    logic [DOT_W-1:0]  r_dot;
    logic [31:0]       r_scale, r_term, r_sum, r_out;
    logic [DOT_W-1:0]  lane_sum;
    logic signed [15:0] lane_p;
    logic [31:0]       scale_p, term_p, add_s, acc_in, dot_f;
    logic [DOT_W-1:0]  dmag;
    int                lz;

    always_comb begin
        lane_sum = '0;
        lane_p   = '0;
        for (int i = 0; i < LANES; i++) begin
            lane_p   = $signed(r_x[i*8 +: 8]) * $signed(r_y[i*8 +: 8]);
            lane_sum = lane_sum + DOT_W'(lane_p);
        end
    end

    // Integer dot to single precision; magnitude fits in 20 bits, so exact.
    always_comb begin
        dmag = r_dot[DOT_W-1] ? DOT_W'(-r_dot) : r_dot;
        lz   = 0;
        for (int i = 0; i < DOT_W; i++) begin
            if (dmag[i]) begin
                lz = i;
            end
        end
        if (dmag == '0) begin
            dot_f = 32'd0;
        end else begin
            dot_f = {r_dot[DOT_W-1], 8'(127 + lz), 23'(({2'b00, dmag} << (23 - lz)))};
        end
    end

    q8dp_fmul u_smul (.i_a(half_to_single(r_xs)), .i_b(half_to_single(r_ys)),
                      .o_p(scale_p));
    q8dp_fmul u_tmul (.i_a(r_scale), .i_b(dot_f), .o_p(term_p));

    assign acc_in = i_cmd.acc_clear ? 32'd0 : r_sum;
    q8dp_fadd u_add (.i_a(acc_in), .i_b(r_term), .o_s(add_s));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x  <= i_x_bytes;
            r_y  <= i_y_bytes;
            r_xs <= i_x_scale;
            r_ys <= i_y_scale;
        end else if (i_cmd.dot_step) begin
            r_x <= r_x >> (LANES * 8);
            r_y <= r_y >> (LANES * 8);
        end
        if (i_cmd.scale_mul) begin
            r_scale <= scale_p;
        end
        if (i_cmd.term_mul) begin
            r_term <= term_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= 32'd0;
            r_out  <= 32'd0;
            r_step <= '0;
            r_dot  <= '0;
        end else begin
            if (i_cmd.load) begin
                r_step <= '0;
                r_dot  <= '0;
            end else if (i_cmd.dot_step) begin
                r_step <= r_step + 1'b1;
                r_dot  <= r_dot + lane_sum;
            end
            if (i_cmd.acc_add) begin
                r_sum <= add_s;
            end
            // Capture the finished sum; any NaN leaves as the canonical quiet NaN.
            if (i_cmd.out_load) begin
                r_out <= ((add_s[30:23] == 8'hFF) && (add_s[22:0] != 23'd0)) ? QNAN : add_s;
            end
        end
    end

    assign o_status.dot_done = i_cmd.dot_step && (r_step == STEP_W'(LANE_STEPS - 1));
    assign o_sum = r_out;
endmodule

FILE: rtl/q8dp_ctrl.sv
// ----------------------------------------------------------------------------
// q8dp_ctrl: sequencer for one block pair
// Issues load, dot steps, scale multiply, term multiply and accumulate.
// ----------------------------------------------------------------------------
module q8dp_ctrl import q8dp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req,
    input  logic    i_first,
    input  logic    i_last,
    input  logic    i_out_taken,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_ready,
    output logic    o_out_valid
);
    t_state r_state, n_state;
    logic   r_first, r_last;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_taken;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_first     <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_ready && i_req) begin
                r_first <= i_first;
                r_last  <= i_last;
            end
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_req) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DOT;
                end
            end
            ST_DOT: begin
                o_cmd.dot_step = 1'b1;
                if (i_status.dot_done) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                o_cmd.scale_mul = 1'b1;
                n_state         = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.term_mul = 1'b1;
                n_state        = ST_ADD;
            end
            ST_ADD: begin
                // Hold a final add while the previous sum still waits to be taken.
                if (!r_last || out_free) begin
                    o_cmd.acc_add   = 1'b1;
                    o_cmd.acc_clear = r_first;
                    o_cmd.out_load  = r_last;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for q8_block_dot_product_core
// Streams block pairs with random gaps, predicts each emitted running sum in
// single precision and compares it with the sum taken from the master side.
// ----------------------------------------------------------------------------
module tb;
    import q8dp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS      = 2000;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN      = 40;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // tdata: x_scale[15:0], y_scale[31:16], x_word0..3[287:32], y_word0..3[543:288]
    logic [543:0] s_axis_tdata;
    // tuser: first_block
    logic         s_axis_tuser;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // tdata: dot_sum[31:0]
    logic [31:0]  m_axis_tdata;

    q8_block_dot_product_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // One request: two scales, two 32-byte blocks (byte 0 in the low bits).
    typedef struct packed {
        logic [15:0]  xs;
        logic [15:0]  ys;
        logic [255:0] xb;
        logic [255:0] yb;
        logic         first;
        logic         last;
    } t_pair;

    typedef struct packed {
        t_pair       pair;
        logic        typed;     // 1: use the value below, not the predictor
        logic [31:0] sum;
    } t_row;

    logic [31:0] expected_sums[$];
    logic [31:0] running_sum;   // predicted accumulator, single-precision bits
    int          fail_count;
    int          idle_cycles;
    bit          calm;          // both sides run without gaps while set

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Single-precision predictor. Products of singles and sums of two
    // singles are formed in double and rounded once to single; with 53
    // bits against 24 that single rounding is the correct one.
    // ------------------------------------------------------------------
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [31:0] m;
        int          e;
        m = {22'd0, h[9:0]};
        if (h[14:10] == 5'd0) begin
            if (m == 0) return {h[15], 31'd0};
            e = 113;
            while (m[10] == 1'b0) begin
                m = m << 1;
                e--;
            end
            return {h[15], 8'(e), m[9:0], 13'd0};
        end
        if (h[14:10] == 5'd31) return {h[15], 8'hFF, h[9:0], 13'd0};
        return {h[15], 8'(h[14:10] + 8'd112), h[9:0], 13'd0};
    endfunction

    function automatic real single_to_real(input logic [31:0] b);
        real r;
        if (b[30:23] == 8'hFF)
            return $bitstoreal({b[31], 11'h7FF, (b[22:0] != 0), 51'd0});
        if (b[30:23] == 8'd0) begin
            if (b[22:0] == 0) return $bitstoreal({b[31], 63'd0});
            // man * 2^-149, exact in double
            r = real'(b[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
            return b[31] ? -r : r;
        end
        return $bitstoreal({b[31], 11'(b[30:23] + 11'd896), b[22:0], 29'd0});
    endfunction

    // Round a double to single, nearest-even, subnormals kept.
    function automatic logic [31:0] round_single(input real r);
        logic [63:0] d, sig, kept, rem, half, val;
        int          ex, sh;
        d  = $realtobits(r);
        ex = int'(d[62:52]);
        if (ex == 2047) return (d[51:0] != 0) ? QNAN : {d[63], 8'hFF, 23'd0};
        if (ex == 0) return {d[63], 31'd0};
        ex  = ex - 1023;
        sig = {11'd0, 1'b1, d[51:0]};
        sh  = (ex >= -126) ? 29 : 29 + (-126 - ex);
        if (sh > 54) return {d[63], 31'd0};
        kept = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
        // implicit bit of kept carries into the exponent field
        val = (ex >= -126) ? ((64'(ex + 126) << 23) + kept) : kept;
        if (val >= 64'h7F80_0000) return {d[63], 8'hFF, 23'd0};
        return {d[63], val[30:0]};
    endfunction

    function automatic int byte_dot(input logic [255:0] xb, input logic [255:0] yb);
        int acc;
        acc = 0;
        for (int i = 0; i < BYTES_PER_BLOCK; i++)
            acc += int'($signed(xb[8*i +: 8])) * int'($signed(yb[8*i +: 8]));
        return acc;
    endfunction

    // Advance the predicted sum by one pair; return the sum after the add.
    function automatic logic [31:0] accumulate_pair(input t_pair p);
        logic [31:0] scale, term;
        scale = round_single(single_to_real(widen_half(p.xs)) *
                             single_to_real(widen_half(p.ys)));
        term  = round_single(single_to_real(scale) * real'(byte_dot(p.xb, p.yb)));
        if (p.first) running_sum = 32'd0;
        running_sum = round_single(single_to_real(running_sum) + single_to_real(term));
        if (running_sum[30:23] == 8'hFF && running_sum[22:0] != 0) return QNAN;
        return running_sum;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [15:0] pick_scale();
        int r;
        r = $urandom_range(99);
        if (r < 60) return {1'($urandom), 5'($urandom_range(20, 10)), 10'($urandom)};
        if (r < 70) return {1'($urandom), 5'd0, 10'($urandom)};       // subnormal
        if (r < 75) return {1'($urandom), 5'd31, 10'($urandom_range(1))}; // inf / nan
        if (r < 80) return {1'($urandom), 15'h7BFF};                  // largest finite
        if (r < 83) return {1'($urandom), 15'd0};                     // signed zero
        return 16'($urandom);
    endfunction

    function automatic logic [255:0] pick_bytes();
        logic [255:0] b;
        int           r;
        r = $urandom_range(9);
        for (int i = 0; i < 8; i++) b[32*i +: 32] = $urandom;
        if (r == 0) b = {32{8'h80}};
        if (r == 1) b = {32{8'h7F}};
        if (r == 2) for (int i = 0; i < 32; i++) if ($urandom_range(1)) b[8*i +: 8] = 8'h80;
        return b;
    endfunction

    // Present one request and hold it until taken; queue its result if it is a final pair.
    task automatic send_pair(input t_pair p, input logic typed, input logic [31:0] sum);
        int          gap;
        logic [31:0] pred;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p.yb, p.xb, p.ys, p.xs};
        s_axis_tuser  <= p.first;
        s_axis_tlast  <= p.last;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = accumulate_pair(p);
        if (p.last) expected_sums.push_back(typed ? sum : pred);
    endtask

    // Drain side: take sums with random stalls and check them in order.
    int sink_hold;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_sums.size() == 0) begin
                $error("dot_sum: unexpected result, actual %h", m_axis_tdata);
                fail_count++;
            end else begin
                if (m_axis_tdata !== expected_sums[0]) begin
                    $error("dot_sum: expected %h actual %h", expected_sums[0], m_axis_tdata);
                    fail_count++;
                end
                void'(expected_sums.pop_front());
            end
        end
        if (sink_hold > 0) begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            sink_hold = pick_gap();
            m_axis_tready <= (sink_hold == 0);
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    t_row directed[$];

    function automatic t_pair mk(input logic [15:0] xs, input logic [15:0] ys,
                                 input logic [255:0] xb, input logic [255:0] yb,
                                 input logic first, input logic last);
        t_pair p;
        p = '{xs, ys, xb, yb, first, last};
        return p;
    endfunction

    initial begin
        t_pair p;
        int    items;
        int    len;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        running_sum   = 32'd0;
        fail_count    = 0;
        idle_cycles   = 0;
        sink_hold     = 0;
        calm          = 1'b0;

        // Typed rows all start a new sum, so their value is plain to see.
        directed.push_back('{mk(16'h0000, 16'h0000, '0, '0, 1, 1), 1, 32'h0000_0000});
        directed.push_back('{mk(16'h3C00, 16'h3C00, {32{8'h01}}, {32{8'h01}}, 1, 1),
                             1, 32'h4200_0000});
        directed.push_back('{mk(16'h3C00, 16'h3C00, {32{8'h80}}, {32{8'h80}}, 1, 1),
                             1, 32'h4900_0000});
        directed.push_back('{mk(16'h3C00, 16'h3C00, {32{8'h80}}, {32{8'h7F}}, 1, 1), 0, 0});
        directed.push_back('{mk(16'h7BFF, 16'hFBFF, {32{8'h7F}}, {32{8'h7F}}, 1, 1), 0, 0});
        directed.push_back('{mk(16'h7C00, 16'h3C00, {32{8'h01}}, {32{8'h01}}, 1, 1),
                             1, 32'h7F80_0000});
        directed.push_back('{mk(16'hFC00, 16'h3C00, {32{8'h01}}, {32{8'h01}}, 1, 1),
                             1, 32'hFF80_0000});
        directed.push_back('{mk(16'h7E00, 16'h3C00, {32{8'h01}}, {32{8'h01}}, 1, 1),
                             1, QNAN});
        directed.push_back('{mk(16'hFFFF, 16'h3C00, {32{8'h01}}, {32{8'h01}}, 1, 1),
                             1, QNAN});
        // infinity times a zero dot product
        directed.push_back('{mk(16'h7C00, 16'h3C00, '0, {32{8'h55}}, 1, 1), 1, QNAN});
        // negative zero scale: +0 plus -0 gives +0
        directed.push_back('{mk(16'h8000, 16'h3C00, {32{8'h01}}, {32{8'h01}}, 1, 1),
                             1, 32'h0000_0000});
        directed.push_back('{mk(16'h0001, 16'h0001, {32{8'h01}}, {32{8'h01}}, 1, 1), 0, 0});
        directed.push_back('{mk(16'h03FF, 16'h8001, {32{8'hFF}}, {32{8'h80}}, 1, 1), 0, 0});
        // three-pair sum, middle pair with neither flag
        directed.push_back('{mk(16'h3800, 16'h4000, {32{8'h12}}, {32{8'hF3}}, 1, 0), 0, 0});
        directed.push_back('{mk(16'h1400, 16'h3C00, {32{8'h7F}}, {32{8'h01}}, 0, 0), 0, 0});
        directed.push_back('{mk(16'h5A00, 16'hB800, {32{8'h81}}, {32{8'h02}}, 0, 1), 0, 0});
        // keep adding after an emitted sum without a first flag
        directed.push_back('{mk(16'h3C00, 16'h3C00, {32{8'h03}}, {32{8'hFD}}, 0, 1), 0, 0});
        directed.push_back('{mk(16'h7BFF, 16'h7BFF, {32{8'h80}}, {32{8'h80}}, 1, 0), 0, 0});
        directed.push_back('{mk(16'h0200, 16'h0001, {32{8'hAA}}, {32{8'h55}}, 0, 1), 0, 0});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i])
            send_pair(directed[i].pair, directed[i].typed, directed[i].sum);

        // Mostly well-formed runs of one to eight pairs; some loose flags.
        items = 0;
        while (items < ITEMS) begin
            calm = ($urandom_range(7) == 0);
            len  = $urandom_range(8, 1);
            for (int k = 0; k < len; k++) begin
                p = mk(pick_scale(), pick_scale(), pick_bytes(), pick_bytes(),
                       k == 0, k == len - 1);
                if ($urandom_range(9) == 0) begin
                    p.first = 1'($urandom);
                    p.last  = 1'($urandom);
                end
                send_pair(p, 1'b0, 32'd0);
                items++;
            end
        end
        @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

FILE: q8_block_dot_product_core.f
rtl/q8dp_pkg.sv
rtl/q8dp_fmul.sv
rtl/q8dp_fadd.sv
rtl/q8dp_datapath.sv
rtl/q8dp_ctrl.sv
rtl/q8_block_dot_product_core.sv
tb/tb.sv
